/* design/crcdf_pkg.sv */
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared constants, types and functions of the CRC-32 frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  localparam int HEADER_BYTES = 28;
  localparam int FIXED_BYTES  = 12;
  localparam int NONCE_BYTES  = HEADER_BYTES - FIXED_BYTES;

  localparam logic [31:0] MAGIC_WORD = 32'h4C4D4350;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  localparam logic [7:0] VERSION_OK     = 8'h01;
  localparam logic [7:0] OPC_LOW_FIRST  = 8'h01;
  localparam logic [7:0] OPC_LOW_LAST   = 8'h06;
  localparam logic [7:0] OPC_HIGH_FIRST = 8'h81;
  localparam logic [7:0] OPC_HIGH_LAST  = 8'h86;

  localparam logic [15:0] LIMIT_RESET = 16'd1024;

  // Byte positions inside the frame, counted from the first magic byte.
  localparam logic [15:0] POS_VERSION  = 16'd4;
  localparam logic [15:0] POS_OPCODE   = 16'd5;
  localparam logic [15:0] POS_LEN_LO   = 16'd6;
  localparam logic [15:0] POS_LEN_HI   = 16'd7;
  localparam logic [15:0] POS_REQ_LAST = 16'(FIXED_BYTES - 1);
  localparam logic [15:0] NONCE_LAST   = 16'(NONCE_BYTES - 1);
  localparam logic [1:0]  TRAILER_LAST = 2'd3;
  localparam logic [1:0]  WINDOW_FULL  = 2'd3;

  localparam logic [2:0] EV_NONCE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_DROP     = 3'd3;
  localparam logic [2:0] EV_BAD_HDR  = 3'd4;
  localparam logic [2:0] EV_BAD_CRC  = 3'd5;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_NONCE   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_TRAILER = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] offset;
    logic [7:0]  opcode;
    logic [15:0] length;
    logic [31:0] request;
  } event_t;

  // Reflected CRC-32 update by one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic opcode_ok(input logic [7:0] op);
    return ((op >= OPC_LOW_FIRST) && (op <= OPC_LOW_LAST)) ||
           ((op >= OPC_HIGH_FIRST) && (op <= OPC_HIGH_LAST));
  endfunction

  // CRC state after the four magic bytes, folded at elaboration.
  localparam logic [31:0] MAGIC_CRC =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, MAGIC_WORD[31:24]),
      MAGIC_WORD[23:16]), MAGIC_WORD[15:8]), MAGIC_WORD[7:0]);

endpackage

/* design/crcdf_if.sv */
// ----------------------------------------------------------------------------
// crcdf_if
// Valid/ready channel interfaces: byte input, event output, limit write.
// ----------------------------------------------------------------------------
interface crcdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface crcdf_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_offset;
  logic [7:0]  frame_opcode;
  logic [15:0] payload_length;
  logic [31:0] request_number;
  modport source (output valid, output event_kind, output data_byte, output byte_offset,
                  output frame_opcode, output payload_length, output request_number,
                  input ready);
  modport sink (input valid, input event_kind, input data_byte, input byte_offset,
                input frame_opcode, input payload_length, input request_number,
                output ready);
endinterface

interface crcdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_limit;
  modport source (output valid, output payload_limit, input ready);
  modport sink (input valid, input payload_limit, output ready);
endinterface

/* design/crc32_frame_deframer.sv */
// ----------------------------------------------------------------------------
// crc32_frame_deframer
// Byte-stream deframer: magic hunt, header check, CRC-32 trailer check.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream carries one received byte per transaction. event_stream
//   carries one event per transaction: a nonce or payload byte with its
//   offset, a dropped byte while hunting, or a frame verdict (good frame,
//   bad header, bad CRC) together with the header fields of the frame.
//   cfg writes the payload length limit; it is always ready and should be
//   written only while no byte is in flight.
// Timing:
//   One byte is taken per cycle while event_stream is not stalled. A byte is
//   parsed straight from the input register once the parser takes it; its
//   event, if any, is then held in the event output register. The CRC update
//   of a byte is one unrolled XOR network, which sets the one-byte-per-cycle rate.
// Reset:
//   Synchronous rst returns to hunting with an empty window, sets the CRC
//   to all ones, sets the limit to 1024 and empties both registers.
// Stalls:
//   While event_stream is stalled the pending event holds, one more byte
//   waits in the input register, and byte_stream then deasserts ready.
// ----------------------------------------------------------------------------
module crc32_frame_deframer (
  input logic            clk,
  input logic            rst,
  crcdf_byte_if.sink     byte_stream,
  crcdf_event_if.source  event_stream,
  crcdf_cfg_if.sink      cfg
);

  logic [15:0]       payload_limit;
  logic              take;
  crcdf_pkg::stage_t stage;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= crcdf_pkg::LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      payload_limit <= cfg.payload_limit;
    end
  end

  crcdf_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .take        (take),
    .stage       (stage)
  );

  crcdf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .stage         (stage),
    .take          (take),
    .payload_limit (payload_limit),
    .event_stream  (event_stream)
  );

endmodule

/* design/crcdf_in_reg.sv */
// ----------------------------------------------------------------------------
// crcdf_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module crcdf_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  crcdf_byte_if.sink           byte_stream,
  input  logic                 take,
  output crcdf_pkg::stage_t    stage
);

  logic       held;
  logic [7:0] held_byte;

  // A new byte may enter whenever the slot is empty or drains this cycle.
  assign byte_stream.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      held_byte <= byte_stream.in_byte;
    end
  end

  assign stage.valid = held;
  assign stage.data  = held_byte;

endmodule

/* design/crcdf_parser.sv */
// ----------------------------------------------------------------------------
// crcdf_parser
// Frame state machine, CRC update and event output register.
// ----------------------------------------------------------------------------
module crcdf_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  crcdf_pkg::stage_t    stage,
  output logic                 take,
  input  logic [15:0]          payload_limit,
  crcdf_event_if.source        event_stream
);

  crcdf_pkg::phase_t phase, phase_next;
  logic [31:0] window, window_next;
  logic [1:0]  fill, fill_next;
  logic [15:0] position_count, position_count_next;
  logic [31:0] crc, crc_next;
  logic [7:0]  hdr_version, hdr_version_next;
  logic [7:0]  hdr_opcode, hdr_opcode_next;
  logic [15:0] hdr_length, hdr_length_next;
  logic [31:0] hdr_request, hdr_request_next;
  logic [31:0] trailer, trailer_next;

  logic              out_valid;
  crcdf_pkg::event_t out_event;
  logic              res_valid;
  crcdf_pkg::event_t res;

  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [31:0] win_shift;
  logic [15:0] pos_inc;
  logic        hdr_bad;

  assign take      = stage.valid && (!out_valid || event_stream.ready);
  assign b         = stage.data;
  assign crc_upd   = crcdf_pkg::crc_byte(crc, b);
  assign win_shift = {window[23:0], b};
  assign pos_inc   = position_count + 16'd1;

  always_comb begin
    phase_next          = phase;
    window_next         = window;
    fill_next           = fill;
    position_count_next = position_count;
    crc_next            = crc;
    hdr_version_next    = hdr_version;
    hdr_opcode_next     = hdr_opcode;
    hdr_length_next     = hdr_length;
    hdr_request_next    = hdr_request;
    trailer_next        = trailer;
    hdr_bad             = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;

    case (phase)
      crcdf_pkg::PH_HUNT: begin
        window_next = win_shift;
        if (fill != crcdf_pkg::WINDOW_FULL) begin
          fill_next = fill + 2'd1;
        end else if (win_shift == crcdf_pkg::MAGIC_WORD) begin
          crc_next            = crcdf_pkg::MAGIC_CRC;
          hdr_version_next    = '0;
          hdr_opcode_next     = '0;
          hdr_length_next     = '0;
          hdr_request_next    = '0;
          position_count_next = crcdf_pkg::POS_VERSION;
          phase_next          = crcdf_pkg::PH_HEADER;
        end else begin
          res_valid = 1'b1;
          res.kind  = crcdf_pkg::EV_DROP;
          res.data  = win_shift[31:24];
        end
      end

      crcdf_pkg::PH_HEADER: begin
        crc_next = crc_upd;
        if (position_count == crcdf_pkg::POS_VERSION) begin
          hdr_version_next = b;
        end else if (position_count == crcdf_pkg::POS_OPCODE) begin
          hdr_opcode_next = b;
        end else if (position_count == crcdf_pkg::POS_LEN_LO) begin
          hdr_length_next = {8'd0, b};
        end else if (position_count == crcdf_pkg::POS_LEN_HI) begin
          hdr_length_next = {b, hdr_length[7:0]};
        end else begin
          // Request id bytes arrive little-endian at positions 8 to 11.
          case (position_count[1:0])
            2'd0:    hdr_request_next[7:0]   = b;
            2'd1:    hdr_request_next[15:8]  = b;
            2'd2:    hdr_request_next[23:16] = b;
            default: hdr_request_next[31:24] = b;
          endcase
        end

        if (position_count != crcdf_pkg::POS_REQ_LAST) begin
          position_count_next = pos_inc;
        end else begin
          hdr_bad = (hdr_version != crcdf_pkg::VERSION_OK) ||
                    !crcdf_pkg::opcode_ok(hdr_opcode) ||
                    (hdr_request_next == 32'd0) ||
                    (hdr_length > payload_limit);
          if (hdr_bad) begin
            res_valid   = 1'b1;
            res.kind    = crcdf_pkg::EV_BAD_HDR;
            res.opcode  = hdr_opcode;
            res.length  = hdr_length;
            res.request = hdr_request_next;
            phase_next          = crcdf_pkg::PH_HUNT;
            window_next         = '0;
            fill_next           = '0;
            position_count_next = '0;
            crc_next            = crcdf_pkg::CRC_INIT;
          end else begin
            position_count_next = '0;
            phase_next          = crcdf_pkg::PH_NONCE;
          end
        end
      end

      crcdf_pkg::PH_NONCE: begin
        crc_next    = crc_upd;
        res_valid   = 1'b1;
        res.kind    = crcdf_pkg::EV_NONCE;
        res.data    = b;
        res.offset  = position_count;
        res.opcode  = hdr_opcode;
        res.length  = hdr_length;
        res.request = hdr_request;
        if (position_count != crcdf_pkg::NONCE_LAST) begin
          position_count_next = pos_inc;
        end else begin
          position_count_next = '0;
          trailer_next        = '0;
          phase_next = (hdr_length == 16'd0) ? crcdf_pkg::PH_TRAILER : crcdf_pkg::PH_PAYLOAD;
        end
      end

      crcdf_pkg::PH_PAYLOAD: begin
        crc_next    = crc_upd;
        res_valid   = 1'b1;
        res.kind    = crcdf_pkg::EV_PAYLOAD;
        res.data    = b;
        res.offset  = position_count;
        res.opcode  = hdr_opcode;
        res.length  = hdr_length;
        res.request = hdr_request;
        if (pos_inc < hdr_length) begin
          position_count_next = pos_inc;
        end else begin
          position_count_next = '0;
          trailer_next        = '0;
          phase_next          = crcdf_pkg::PH_TRAILER;
        end
      end

      crcdf_pkg::PH_TRAILER: begin
        case (position_count[1:0])
          2'd0:    trailer_next[7:0]   = b;
          2'd1:    trailer_next[15:8]  = b;
          2'd2:    trailer_next[23:16] = b;
          default: trailer_next[31:24] = b;
        endcase
        if (position_count[1:0] != crcdf_pkg::TRAILER_LAST) begin
          position_count_next = pos_inc;
        end else begin
          res_valid   = 1'b1;
          res.kind    = (trailer_next == ~crc) ? crcdf_pkg::EV_GOOD : crcdf_pkg::EV_BAD_CRC;
          res.opcode  = hdr_opcode;
          res.length  = hdr_length;
          res.request = hdr_request;
          phase_next          = crcdf_pkg::PH_HUNT;
          window_next         = '0;
          fill_next           = '0;
          position_count_next = '0;
          crc_next            = crcdf_pkg::CRC_INIT;
        end
      end

      default: begin
        phase_next          = crcdf_pkg::PH_HUNT;
        window_next         = '0;
        fill_next           = '0;
        position_count_next = '0;
        crc_next            = crcdf_pkg::CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= crcdf_pkg::PH_HUNT;
      window         <= '0;
      fill           <= '0;
      position_count <= '0;
      crc            <= crcdf_pkg::CRC_INIT;
    end else if (take) begin
      phase          <= phase_next;
      window         <= window_next;
      fill           <= fill_next;
      position_count <= position_count_next;
      crc            <= crc_next;
    end
  end

  // Header and trailer fields are always written before they are read.
  always_ff @(posedge clk) begin
    if (take) begin
      hdr_version <= hdr_version_next;
      hdr_opcode  <= hdr_opcode_next;
      hdr_length  <= hdr_length_next;
      hdr_request <= hdr_request_next;
      trailer     <= trailer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (event_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_event <= res;
    end
  end

  assign event_stream.valid          = out_valid;
  assign event_stream.event_kind     = out_event.kind;
  assign event_stream.data_byte      = out_event.data;
  assign event_stream.byte_offset    = out_event.offset;
  assign event_stream.frame_opcode   = out_event.opcode;
  assign event_stream.payload_length = out_event.length;
  assign event_stream.request_number = out_event.request;

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == crcdf_pkg::PH_HEADER) |->
      (position_count >= crcdf_pkg::POS_VERSION) && (position_count <= crcdf_pkg::POS_REQ_LAST))
    else $error("header position out of range");

  a_nonce_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == crcdf_pkg::PH_NONCE) |-> (position_count <= crcdf_pkg::NONCE_LAST))
    else $error("nonce position out of range");

  a_payload_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == crcdf_pkg::PH_PAYLOAD) |-> (position_count < hdr_length))
    else $error("payload position beyond declared length");

  a_trailer_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == crcdf_pkg::PH_TRAILER) |-> (position_count[15:2] == 14'd0))
    else $error("trailer position out of range");

  a_recover: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && ((res.kind == crcdf_pkg::EV_BAD_HDR) ||
      (res.kind == crcdf_pkg::EV_GOOD) || (res.kind == crcdf_pkg::EV_BAD_CRC))) |=>
      ((phase == crcdf_pkg::PH_HUNT) && (fill == 2'd0) && (crc == crcdf_pkg::CRC_INIT)))
    else $error("frame end did not return to hunting");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for crc32_frame_deframer. A table of directed bytes
// covers the window fill, dropped bytes and two bad headers. Random
// byte streams follow: good frames, CRC errors, bad headers, cut frames and
// line noise, under several payload limits. A byte-level model predicts the
// events (typed table rows give their own), compared field by field at the event port.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FLUSH_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 60;
  localparam int MAX_PRINTS     = 40;

  typedef enum {
    FR_GOOD, FR_BAD_CRC, FR_BAD_VERSION, FR_BAD_OPCODE, FR_ZERO_REQ, FR_OVER_LIMIT,
    FR_TRUNCATED
  } frame_kind_t;

  typedef struct packed {
    logic [7:0]        value;
    logic              typed;
    crcdf_pkg::event_t want;
  } drive_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crcdf_byte_if  byte_bus ();
  crcdf_event_if event_bus ();
  crcdf_cfg_if   cfg_bus ();

  crc32_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_bus),
    .event_stream (event_bus),
    .cfg          (cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Deframer model state.
  crcdf_pkg::phase_t st_phase;
  logic [31:0] st_window;
  logic [2:0]  st_fill;
  logic [15:0] st_pos;
  logic [31:0] st_crc;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_opcode;
  logic [15:0] hdr_length;
  logic [31:0] hdr_request;
  logic [31:0] trl_crc;
  logic [15:0] limit_reg;

  crcdf_pkg::event_t expected_events [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_cycle = 0;
  int unsigned ready_mode = 0;

  drive_row_t  directed_rows [26];

  // Bit-serial form of the reflected CRC-32, data LSB first.
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c = c >> 1;
      if (fb) c = c ^ crcdf_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic opcode_in_range(input logic [7:0] op);
    return (op >= crcdf_pkg::OPC_LOW_FIRST && op <= crcdf_pkg::OPC_LOW_LAST) ||
           (op >= crcdf_pkg::OPC_HIGH_FIRST && op <= crcdf_pkg::OPC_HIGH_LAST);
  endfunction

  function automatic crcdf_pkg::event_t frame_event(input logic [2:0] kind,
                                                    input logic [7:0] data,
                                                    input logic [15:0] offset);
    crcdf_pkg::event_t ev;
    ev.kind    = kind;
    ev.data    = data;
    ev.offset  = offset;
    ev.opcode  = hdr_opcode;
    ev.length  = hdr_length;
    ev.request = hdr_request;
    return ev;
  endfunction

  function automatic drive_row_t plain(input logic [7:0] b);
    drive_row_t r;
    r.value = b;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic drive_row_t with_event(input logic [7:0] b, input logic [2:0] kind,
                                            input logic [7:0] data, input logic [7:0] op,
                                            input logic [15:0] len, input logic [31:0] req);
    drive_row_t r;
    r.value = b;
    r.typed = 1'b1;
    r.want  = {kind, data, 16'h0000, op, len, req};
    return r;
  endfunction

  task automatic restart_hunt();
    st_phase  = crcdf_pkg::PH_HUNT;
    st_window = '0;
    st_fill   = '0;
    st_pos    = '0;
    st_crc    = crcdf_pkg::CRC_INIT;
  endtask

  // Advances the model by one received byte; got tells whether an event results.
  task automatic deframe_byte(input logic [7:0] b, output logic got,
                              output crcdf_pkg::event_t ev);
    logic [15:0] pos;
    pos = st_pos;
    got = 1'b0;
    ev  = '0;
    case (st_phase)
      crcdf_pkg::PH_HUNT: begin
        st_window = {st_window[23:0], b};
        if (st_fill != 3'd4) st_fill = st_fill + 3'd1;
        if (st_fill == 3'd4) begin
          if (st_window == crcdf_pkg::MAGIC_WORD) begin
            st_crc = crcdf_pkg::CRC_INIT;
            for (int i = 3; i >= 0; i--) st_crc = crc32_shift_byte(st_crc, st_window[8*i +: 8]);
            hdr_version = '0;
            hdr_opcode  = '0;
            hdr_length  = '0;
            hdr_request = '0;
            st_phase    = crcdf_pkg::PH_HEADER;
            st_pos      = crcdf_pkg::POS_VERSION;
          end else begin
            // The oldest byte leaves the window; the other three stay.
            st_fill = 3'd3;
            got     = 1'b1;
            ev.kind = crcdf_pkg::EV_DROP;
            ev.data = st_window[31:24];
          end
        end
      end
      crcdf_pkg::PH_HEADER: begin
        st_crc = crc32_shift_byte(st_crc, b);
        if (pos == crcdf_pkg::POS_VERSION) hdr_version = b;
        else if (pos == crcdf_pkg::POS_OPCODE) hdr_opcode = b;
        else if (pos == crcdf_pkg::POS_LEN_LO) hdr_length[7:0] = b;
        else if (pos == crcdf_pkg::POS_LEN_HI) hdr_length[15:8] = b;
        else hdr_request[8*(pos - crcdf_pkg::POS_LEN_HI - 16'd1) +: 8] = b;
        if (pos != crcdf_pkg::POS_REQ_LAST) begin
          st_pos = pos + 16'd1;
        end else if (hdr_version != crcdf_pkg::VERSION_OK || !opcode_in_range(hdr_opcode) ||
                     hdr_request == '0 || hdr_length > limit_reg) begin
          got = 1'b1;
          ev  = frame_event(crcdf_pkg::EV_BAD_HDR, 8'h00, 16'h0000);
          restart_hunt();
        end else begin
          st_phase = crcdf_pkg::PH_NONCE;
          st_pos   = '0;
        end
      end
      crcdf_pkg::PH_NONCE: begin
        st_crc = crc32_shift_byte(st_crc, b);
        got    = 1'b1;
        ev     = frame_event(crcdf_pkg::EV_NONCE, b, pos);
        if (pos != crcdf_pkg::NONCE_LAST) begin
          st_pos = pos + 16'd1;
        end else begin
          st_pos   = '0;
          trl_crc  = '0;
          st_phase = (hdr_length == '0) ? crcdf_pkg::PH_TRAILER : crcdf_pkg::PH_PAYLOAD;
        end
      end
      crcdf_pkg::PH_PAYLOAD: begin
        st_crc = crc32_shift_byte(st_crc, b);
        got    = 1'b1;
        ev     = frame_event(crcdf_pkg::EV_PAYLOAD, b, pos);
        if ({1'b0, pos} + 17'd1 < {1'b0, hdr_length}) begin
          st_pos = pos + 16'd1;
        end else begin
          st_pos   = '0;
          trl_crc  = '0;
          st_phase = crcdf_pkg::PH_TRAILER;
        end
      end
      crcdf_pkg::PH_TRAILER: begin
        trl_crc[8*pos[1:0] +: 8] = b;
        if (pos[1:0] != crcdf_pkg::TRAILER_LAST) begin
          st_pos = pos + 16'd1;
        end else begin
          got = 1'b1;
          ev  = frame_event((trl_crc == ~st_crc) ? crcdf_pkg::EV_GOOD : crcdf_pkg::EV_BAD_CRC,
                            8'h00, 16'h0000);
          restart_hunt();
        end
      end
      default: restart_hunt();
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] event mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Sends one byte in bursts with random gaps; a typed row overrides the model's event.
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input crcdf_pkg::event_t want);
    int unsigned       gap;
    logic              got;
    crcdf_pkg::event_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        byte_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_bus.valid   <= 1'b1;
    byte_bus.in_byte <= b;
    do @(posedge clk); while (!(byte_bus.valid && byte_bus.ready));
    bytes_sent++;
    deframe_byte(b, got, pred);
    if (typed) expected_events.push_back(want);
    else if (got) expected_events.push_back(pred);
  endtask

  task automatic send_random_byte();
    logic [31:0] rnd;
    rnd = $urandom;
    send_byte(rnd[7:0], 1'b0, '0);
  endtask

  // Lets the deframer run dry, then writes a new payload limit.
  task automatic write_limit(input logic [15:0] value);
    byte_bus.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.payload_limit <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    limit_reg = value;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t mode, input logic [15:0] len);
    logic [7:0]  frame_bytes [$];
    logic [31:0] rnd;
    logic [31:0] req;
    logic [31:0] crc;
    logic [7:0]  ver;
    logic [7:0]  op;
    int unsigned idx;
    int unsigned stop;
    ver = crcdf_pkg::VERSION_OK;
    idx = $urandom_range(0, 11);
    op  = (idx < 6) ? crcdf_pkg::OPC_LOW_FIRST + 8'(idx)
                    : crcdf_pkg::OPC_HIGH_FIRST + 8'(idx - 6);
    case ($urandom_range(0, 3))
      0: req = 32'h0000_0001;
      1: req = 32'hFFFF_FFFF;
      default: begin
        req = $urandom;
        if (req == '0) req = 32'h0000_0001;
      end
    endcase
    case (mode)
      FR_BAD_VERSION:
        do begin rnd = $urandom; ver = rnd[7:0]; end while (ver == crcdf_pkg::VERSION_OK);
      FR_BAD_OPCODE:  do begin rnd = $urandom; op = rnd[7:0]; end while (opcode_in_range(op));
      FR_ZERO_REQ:    req = '0;
      default: ;
    endcase
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(crcdf_pkg::MAGIC_WORD[8*i +: 8]);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(op);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(req[8*i +: 8]);
    // A rejected header ends the frame; the rest would only be hunted as noise.
    if (mode inside {FR_GOOD, FR_BAD_CRC, FR_TRUNCATED}) begin
      repeat (crcdf_pkg::NONCE_BYTES + int'(len)) begin
        rnd = $urandom;
        frame_bytes.push_back(rnd[7:0]);
      end
      crc = crcdf_pkg::CRC_INIT;
      foreach (frame_bytes[i]) crc = crc32_shift_byte(crc, frame_bytes[i]);
      crc = ~crc;
      if (mode == FR_BAD_CRC) crc = crc ^ (32'h1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
    end
    stop = (mode == FR_TRUNCATED) ? $urandom_range(5, frame_bytes.size() - 1)
                                  : frame_bytes.size();
    for (int i = 0; i < int'(stop); i++) send_byte(frame_bytes[i], 1'b0, '0);
  endtask

  // Receiver: ready follows a randomly chosen stall pattern, from always ready to mostly stalled.
  always @(posedge clk) begin
    if (rst) begin
      event_bus.ready <= 1'b0;
    end else begin
      ready_cycle++;
      if (ready_cycle % 48 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0, 1: event_bus.ready <= 1'b1;
        2: event_bus.ready <= ($urandom_range(0, 3) != 0);
        default: event_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    crcdf_pkg::event_t want;
    if (!rst && event_bus.valid && event_bus.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with nothing expected, kind", event_bus.event_kind, '0);
      end else begin
        want = expected_events.pop_front();
        if (event_bus.event_kind != want.kind)
          report_mismatch("event_kind", event_bus.event_kind, want.kind);
        if (event_bus.data_byte != want.data)
          report_mismatch("data_byte", event_bus.data_byte, want.data);
        if (event_bus.byte_offset != want.offset)
          report_mismatch("byte_offset", event_bus.byte_offset, want.offset);
        if (event_bus.frame_opcode != want.opcode)
          report_mismatch("frame_opcode", event_bus.frame_opcode, want.opcode);
        if (event_bus.payload_length != want.length)
          report_mismatch("payload_length", event_bus.payload_length, want.length);
        if (event_bus.request_number != want.request)
          report_mismatch("request_number", event_bus.request_number, want.request);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_bus.valid && byte_bus.ready) || (event_bus.valid && event_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0]  phase_limits [5];
    int unsigned  target;
    int unsigned  pick;
    int unsigned  noise;
    int unsigned  cap;
    frame_kind_t  mode;
    logic [15:0]  len;

    byte_bus.valid        <= 1'b0;
    byte_bus.in_byte      <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.payload_limit <= '0;

    limit_reg   = crcdf_pkg::LIMIT_RESET;
    hdr_version = '0;
    hdr_opcode  = '0;
    hdr_length  = '0;
    hdr_request = '0;
    trl_crc     = '0;
    restart_hunt();

    directed_rows = '{
      // Window fills over three bytes, then two dropped bytes and the magic.
      plain(8'h00), plain(8'hFF), plain(8'h4C),
      with_event(8'h4D, crcdf_pkg::EV_DROP, 8'h00, 8'h00, 16'h0000, 32'h0000_0000),
      with_event(8'h43, crcdf_pkg::EV_DROP, 8'hFF, 8'h00, 16'h0000, 32'h0000_0000),
      plain(8'h50),
      // Wrong version, top opcode, largest length, zero request id.
      plain(8'h02), plain(8'h86), plain(8'hFF), plain(8'hFF),
      plain(8'h00), plain(8'h00), plain(8'h00),
      with_event(8'h00, crcdf_pkg::EV_BAD_HDR, 8'h00, 8'h86, 16'hFFFF, 32'h0000_0000),
      // Hunting restarts empty; then a header with opcode zero and length at the limit.
      plain(8'h4C), plain(8'h4D), plain(8'h43), plain(8'h50),
      plain(8'h01), plain(8'h00), plain(8'h00), plain(8'h04),
      plain(8'hFF), plain(8'hFF), plain(8'hFF),
      with_event(8'hFF, crcdf_pkg::EV_BAD_HDR, 8'h00, 8'h00, crcdf_pkg::LIMIT_RESET,
                 32'hFFFF_FFFF)
    };

    phase_limits[0] = crcdf_pkg::LIMIT_RESET;
    phase_limits[1] = 16'h0000;
    phase_limits[2] = 16'hFFFF;
    phase_limits[3] = 16'd7;
    phase_limits[4] = 16'($urandom_range(8, 300));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_limit(phase_limits[p]);
      target = bytes_sent + PHASE_BYTES;
      // One long payload, with offsets past one byte, once the largest limit is set.
      if (limit_reg == 16'hFFFF) send_frame(FR_GOOD, 16'd280);
      while (bytes_sent < target) begin
        noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        repeat (noise) send_random_byte();
        pick = $urandom_range(0, 99);
        if (pick < 55) mode = FR_GOOD;
        else if (pick < 67) mode = FR_BAD_CRC;
        else if (pick < 72) mode = FR_BAD_VERSION;
        else if (pick < 77) mode = FR_BAD_OPCODE;
        else if (pick < 82) mode = FR_ZERO_REQ;
        else if (pick < 90) mode = FR_OVER_LIMIT;
        else mode = FR_TRUNCATED;
        if (mode == FR_OVER_LIMIT && limit_reg == 16'hFFFF) mode = FR_BAD_VERSION;
        if (mode == FR_OVER_LIMIT) begin
          len = limit_reg + 16'd1 + 16'($urandom_range(0, 65534 - int'(limit_reg)));
        end else begin
          cap = ($urandom_range(0, 7) == 0) ? 80 : 24;
          if (cap > limit_reg) cap = limit_reg;
          len = 16'($urandom_range(0, cap));
        end
        send_frame(mode, len);
      end
    end

    byte_bus.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/crcdf_pkg.sv
design/crcdf_if.sv
design/crcdf_in_reg.sv
design/crcdf_parser.sv
design/crc32_frame_deframer.sv
tb/testbench.sv
